@@ hdl/assert_macros.svh @@
// assertion macros shared by the reverb rtl
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ hdl/mtfr_pkg.sv @@
// shared types, constants and tap offset tables for the reverb
// no dependencies
`default_nettype none

package mtfr_pkg;

	localparam int unsigned DEPTH_DEFAULT = 4096;
	localparam int unsigned LEN_RESET     = 4096;
	localparam int unsigned SAMPLE_W      = 16;
	localparam int unsigned LEN_CFG_W     = 13;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned OFF_W         = 8;
	localparam int unsigned TAB_DEPTH     = 256;
	localparam int unsigned PROD_W        = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_MODE    = 2'd1;

	localparam int unsigned TAP_NEAR      = 103;
	localparam int unsigned TAP_FAR       = 233;
	localparam int unsigned KEEP_Q15      = 22938;
	localparam int unsigned MIX_Q15       = 9830;
	localparam int unsigned Q15_ONE       = 32768;
	localparam int unsigned Q15_SHIFT     = 15;
	localparam int unsigned HALF_SHIFT    = 1;
	localparam int unsigned QUARTER_SHIFT = 2;
	localparam int unsigned EIGHTH_SHIFT  = 3;

	typedef logic [TAB_DEPTH-1:0][OFF_W-1:0] tap_tab_t;

	typedef struct packed {
		logic start;
		logic cap_cur;
		logic cap_near;
		logic adv;
		logic mode;
	} dp_ctrl_t;

	// offset modulo each short length, built at elaboration
	function automatic tap_tab_t mod_table(input int unsigned off);
		tap_tab_t    tab;
		int unsigned r;
		for (int n = 0; n < TAB_DEPTH; n++) begin
			r = off;
			for (int k = 0; k < TAB_DEPTH; k++) begin
				if (n != 0 && r >= n) begin
					r = r - n;
				end
			end
			tab[n] = OFF_W'(r);
		end
		return tab;
	endfunction

	localparam tap_tab_t NEAR_TAB = mod_table(TAP_NEAR);
	localparam tap_tab_t FAR_TAB  = mod_table(TAP_FAR);

endpackage

`default_nettype wire

@@ hdl/mtfr_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// depends on mtfr_pkg for default sizes
`default_nettype none

module mtfr_ram #(
	parameter int unsigned WIDTH = mtfr_pkg::SAMPLE_W,
	parameter int unsigned DEPTH = mtfr_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/mtfr_datapath.sv @@
// sample arithmetic: tap sum, output register and feedback blend
// depends on mtfr_pkg
`default_nettype none

module mtfr_datapath (
	input  logic                                clk,
	input  mtfr_pkg::dp_ctrl_t                  ctrl,
	input  logic signed [mtfr_pkg::SAMPLE_W-1:0] sample_in,
	input  logic signed [mtfr_pkg::SAMPLE_W-1:0] rd_data,
	output logic signed [mtfr_pkg::SAMPLE_W-1:0] y,
	output logic signed [mtfr_pkg::SAMPLE_W-1:0] wr_data
);

	import mtfr_pkg::*;

	localparam logic signed [PROD_W-1:0] KEEP_W = PROD_W'(KEEP_Q15);
	localparam logic signed [PROD_W-1:0] MIX_W  = PROD_W'(MIX_Q15);

	// signed shift right that truncates toward zero
	function automatic logic signed [SAMPLE_W-1:0] trunc_shr(
		input logic signed [SAMPLE_W-1:0] v,
		input int unsigned                k
	);
		logic signed [SAMPLE_W:0] ve;
		logic signed [SAMPLE_W:0] bias;
		logic signed [SAMPLE_W:0] t;
		ve   = (SAMPLE_W+1)'(v);
		bias = v[SAMPLE_W-1] ? (SAMPLE_W+1)'((1 << k) - 1) : '0;
		t    = (ve + bias) >>> k;
		return t[SAMPLE_W-1:0];
	endfunction

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] cur_q;
	logic signed [SAMPLE_W-1:0] near_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic signed [PROD_W-1:0]   keep_q;

	logic signed [SAMPLE_W-1:0] half;
	logic signed [SAMPLE_W-1:0] y_next;
	logic signed [PROD_W-1:0]   cur_ext;
	logic signed [PROD_W-1:0]   y_ext;
	logic signed [PROD_W-1:0]   mix;
	logic signed [PROD_W-1:0]   acc;
	logic signed [PROD_W-1:0]   acc_b;
	logic signed [SAMPLE_W-1:0] blend;

	assign half    = trunc_shr(cur_q, HALF_SHIFT);
	assign cur_ext = PROD_W'(cur_q);
	assign y_ext   = PROD_W'(y_q);

	always_comb begin
		if (ctrl.mode) begin
			y_next = x_q + half;
		end else begin
			y_next = x_q + half + trunc_shr(near_q, QUARTER_SHIFT)
				+ trunc_shr(rd_data, EIGHTH_SHIFT);
		end
	end

	// 0.7 old + 0.3 out in q15, truncated toward zero
	assign mix   = y_ext * MIX_W;
	assign acc   = keep_q + mix;
	assign acc_b = acc + (acc[PROD_W-1] ? PROD_W'(Q15_ONE - 1) : PROD_W'(0));
	assign blend = acc_b[Q15_SHIFT +: SAMPLE_W];

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= sample_in;
		end
		if (ctrl.cap_cur) begin
			cur_q <= rd_data;
		end
		if (ctrl.cap_near) begin
			near_q <= rd_data;
			keep_q <= cur_ext * KEEP_W;
		end
		if (ctrl.adv) begin
			y_q <= y_next;
		end
	end

	assign y       = y_q;
	assign wr_data = ctrl.mode ? y_q : blend;

endmodule

`default_nettype wire

@@ hdl/multi_tap_feedback_reverb.sv @@
// top level of the multi-tap feedback reverb: sequencer, config, delay ram
// depends on mtfr_pkg, mtfr_ram, mtfr_datapath, assert_macros.svh
//
// channel  | signals                                   | dir
// ---------+-------------------------------------------+-----
// in       | in_valid, in_ready, sample_in             | in
// out      | out_valid, out_ready, sample_out          | out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// each item makes three delay reads through the ram read port and then forms the sum;
// the next item starts as the sum phase advances, and its first read overlaps the blend write.
// out_valid is registered as the sum phase advances, after the cur, near and far reads.
// after reset a clearing pass writes zeros to all MAX_DELAY_DEPTH entries
// (4096 by default) with in_ready low; cfg writes are taken at all times.
// a held result stalls the next item in its sum cycle; one more item waits in the input buffer.
`default_nettype none

module multi_tap_feedback_reverb #(
	parameter int unsigned MAX_DELAY_DEPTH = mtfr_pkg::DEPTH_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [mtfr_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mtfr_pkg::SAMPLE_W-1:0]  sample_out,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mtfr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mtfr_pkg::LEN_CFG_W-1:0]        cfg_data
);

	import mtfr_pkg::*;

	`include "assert_macros.svh"

	localparam int unsigned ADDR_W = $clog2(MAX_DELAY_DEPTH);
	localparam int unsigned LEN_W  = $clog2(MAX_DELAY_DEPTH + 1);
	localparam int unsigned AW1    = ADDR_W + 1;

	localparam logic [1:0] PH_CUR  = 2'd0;
	localparam logic [1:0] PH_NEAR = 2'd1;
	localparam logic [1:0] PH_FAR  = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	// config registers
	logic [LEN_W-1:0]  eff_len_q;
	logic [OFF_W-1:0]  near_off_q;
	logic [OFF_W-1:0]  far_off_q;
	logic              echo_mode_q;

	// sequencer and positions
	logic              busy_q;
	logic [1:0]        ph_q;
	logic              busy_d;
	logic [1:0]        ph_d;
	logic [ADDR_W-1:0] wp_q;
	logic              in_vld_q;
	logic signed [SAMPLE_W-1:0] in_q;
	logic              out_valid_q;

	// clearing pass
	logic              clr_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	// write stage and forwarding
	logic              wr_pend_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic              fwd_q;
	logic signed [SAMPLE_W-1:0] fwd_data_q;

	logic              cfg_wr;
	logic              accept;
	logic              adv;
	logic              start;
	logic [31:0]       cfg_v;
	logic [31:0]       eff32;
	logic [LEN_W-1:0]  eff_new;
	logic [OFF_W-1:0]  near_new;
	logic [OFF_W-1:0]  far_new;
	logic [OFF_W-1:0]  off_sel;
	logic [AW1-1:0]    tap_sum;
	logic [AW1-1:0]    eff_w;
	logic [ADDR_W-1:0] tap_addr;
	logic [AW1-1:0]    wp_inc;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic signed [SAMPLE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic signed [SAMPLE_W-1:0] rd_data;
	logic signed [SAMPLE_W-1:0] dp_wr_data;
	logic signed [SAMPLE_W-1:0] y_out;
	dp_ctrl_t          dp_ctrl;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_ready  = !in_vld_q && !clr_q;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign sample_out = y_out;

	assign adv   = busy_q && (ph_q == PH_SUM) && (!out_valid_q || out_ready);
	assign start = in_vld_q && !clr_q && (!busy_q || adv);

	// effective length and tap offsets of a new delay_length
	always_comb begin
		cfg_v = 32'(cfg_data);
		if (cfg_v == 32'd0) begin
			eff32 = 32'd1;
		end else if (cfg_v > MAX_DELAY_DEPTH) begin
			eff32 = 32'(MAX_DELAY_DEPTH);
		end else begin
			eff32 = cfg_v;
		end
		eff_new = LEN_W'(eff32);
		if (eff32 >= TAB_DEPTH) begin
			near_new = OFF_W'(TAP_NEAR);
			far_new  = OFF_W'(TAP_FAR);
		end else begin
			near_new = NEAR_TAB[eff32[OFF_W-1:0]];
			far_new  = FAR_TAB[eff32[OFF_W-1:0]];
		end
	end

	// tap address with one wrap
	assign off_sel  = (ph_q == PH_FAR) ? far_off_q : near_off_q;
	assign eff_w    = AW1'(eff_len_q);
	assign tap_sum  = AW1'(wp_q) + AW1'(off_sel);
	assign tap_addr = (tap_sum >= eff_w) ? ADDR_W'(tap_sum - eff_w) : ADDR_W'(tap_sum);
	assign wp_inc   = AW1'(wp_q) + AW1'(1);

	always_comb begin
		busy_d = busy_q;
		ph_d   = ph_q;
		unique case (ph_q)
			PH_CUR: begin
				if (busy_q) begin
					ph_d = PH_NEAR;
				end
			end
			PH_NEAR: ph_d = PH_FAR;
			PH_FAR:  ph_d = PH_SUM;
			PH_SUM: begin
				if (adv) begin
					busy_d = 1'b0;
					ph_d   = PH_CUR;
				end
			end
		endcase
		if (start) begin
			busy_d = 1'b1;
			ph_d   = PH_CUR;
		end
	end

	always_comb begin
		ram_raddr = wp_q;
		unique case (ph_q)
			PH_CUR:  ram_raddr = wp_q;
			PH_NEAR: ram_raddr = tap_addr;
			PH_FAR:  ram_raddr = tap_addr;
			PH_SUM:  ram_raddr = wp_q;
		endcase
	end

	assign ram_re    = busy_q && (ph_q != PH_SUM);
	assign ram_we    = clr_q || wr_pend_q;
	assign ram_waddr = clr_q ? clr_cnt_q : wr_addr_q;
	assign ram_wdata = clr_q ? '0 : dp_wr_data;
	assign rd_data   = fwd_q ? fwd_data_q : $signed(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ph_q        <= PH_CUR;
			in_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			wp_q        <= '0;
			wr_pend_q   <= 1'b0;
			fwd_q       <= 1'b0;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			eff_len_q   <= LEN_W'(MAX_DELAY_DEPTH < LEN_RESET ? MAX_DELAY_DEPTH : LEN_RESET);
			near_off_q  <= OFF_W'(TAP_NEAR);
			far_off_q   <= OFF_W'(TAP_FAR);
			echo_mode_q <= 1'b0;
		end else begin
			busy_q    <= busy_d;
			ph_q      <= ph_d;
			wr_pend_q <= adv;
			if (accept) begin
				in_vld_q <= 1'b1;
			end else if (start) begin
				in_vld_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				wp_q        <= (wp_inc == eff_w) ? '0 : wp_q + ADDR_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_re) begin
				fwd_q <= ram_we && (ram_waddr == ram_raddr);
			end
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
				if (clr_cnt_q == ADDR_W'(MAX_DELAY_DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_DELAY_LENGTH: begin
						eff_len_q  <= eff_new;
						near_off_q <= near_new;
						far_off_q  <= far_new;
						if (AW1'(wp_q) >= AW1'(eff_new)) begin
							wp_q <= '0;
						end
					end
					REG_ECHO_MODE: echo_mode_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= sample_in;
		end
		if (adv) begin
			wr_addr_q <= wp_q;
		end
		if (ram_re) begin
			fwd_data_q <= ram_wdata;
		end
	end

	assign dp_ctrl.start    = start;
	assign dp_ctrl.cap_cur  = busy_q && (ph_q == PH_NEAR);
	assign dp_ctrl.cap_near = busy_q && (ph_q == PH_FAR);
	assign dp_ctrl.adv      = adv;
	assign dp_ctrl.mode     = echo_mode_q;

	mtfr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_DELAY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mtfr_datapath u_datapath (
		.clk       (clk),
		.ctrl      (dp_ctrl),
		.sample_in (in_q),
		.rd_data   (rd_data),
		.y         (y_out),
		.wr_data   (dp_wr_data)
	);

	`ASSERT_PROP(a_wp_in_range, clk, arst_n, AW1'(wp_q) < AW1'(eff_len_q), "write position past length")
	`ASSERT_PROP(a_raddr_in_range, clk, arst_n, ram_re |-> (AW1'(ram_raddr) < eff_w), "tap address past length")
	`ASSERT_PROP(a_fwd_first_read, clk, arst_n, (ram_re && ram_we && (ram_waddr == ram_raddr)) |-> (ph_q == PH_CUR), "read and write collide beyond the first read")
	`ASSERT_NEVER(a_no_item_in_clear, clk, arst_n, clr_q && busy_q, "item in flight during clearing pass")

endmodule

`default_nettype wire
